[hdl/pcx_rle_pixel_decoder_core_assert.svh]
// Assertion macros used by the checker file of the RLE pixel decoder.
`ifndef PCX_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define PCX_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define PCXD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define PCXD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pcxd_pkg.sv]
`timescale 1ns / 1ps
package pcxd_pkg;

    localparam int PAL_DEPTH        = 256;
    localparam int PAL_AW           = $clog2(PAL_DEPTH);
    localparam int PIXEL_COUNT_BITS = 25;
    localparam int RUN_BITS         = 6;
    localparam int CFG_IDX_BITS     = 3;
    localparam int CFG_DATA_BITS    = 25;
    localparam int IN_DATA_BITS     = 40;
    localparam int PIXEL_BITS       = 32;

    localparam logic [7:0]          RUN_MARK = 8'd192;
    localparam logic [7:0]          RUN_MASK = 8'h3F;

    typedef enum logic {
        REQ_PALETTE = 1'b0,
        REQ_DATA    = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TRUE_COLOR_MODE = 3'd0,
        CFG_RED_WIDTH       = 3'd1,
        CFG_GREEN_WIDTH     = 3'd2,
        CFG_BLUE_WIDTH      = 3'd3,
        CFG_RED_SHIFT       = 3'd4,
        CFG_GREEN_SHIFT     = 3'd5,
        CFG_BLUE_SHIFT      = 3'd6,
        CFG_IMAGE_PIXELS    = 3'd7
    } t_cfg_reg;

    // Input payload, first field in the highest bits.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] pal_blue;
        logic [7:0] pal_green;
        logic [7:0] pal_red;
        logic [7:0] pal_index;
    } t_in_data;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pal_entry;

    typedef struct packed {
        logic       true_color;
        logic [3:0] red_width;
        logic [3:0] green_width;
        logic [3:0] blue_width;
        logic [4:0] red_shift;
        logic [4:0] green_shift;
        logic [4:0] blue_shift;
    } t_colour_cfg;

endpackage

[hdl/pcx_rle_pixel_decoder_core.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// s        | in        | i_s_tvalid / o_s_tready    | i_s_tdata (40), i_s_tuser (1)
// m        | out       | o_m_tvalid / i_m_tready    | o_m_tdata (32), o_m_tuser, o_m_tlast
// cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index (3), i_cfg_data (25)
//
// A palette write or a run header leaves the input ready.
// A byte that yields pixels passes through the palette memory read, then
// the colour packing register, then goes out one pixel per cycle into the
// output register unless stalled; a zero-length run value yields no pixel.
// Reset is synchronous and active low; it clears the decoder state and loads
// the register defaults. The palette memory is not cleared.
// A stall on the output side holds the pixel generator; the input is taken
// again once the last pixel of a byte has been handed to the output register.
module pcx_rle_pixel_decoder_core
    import pcxd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // pal_index, pal_red, pal_green, pal_blue, data_byte (from bit 0 up)
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // req_type
    input  logic                     i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // pixel_value
    output logic [PIXEL_BITS-1:0]    o_m_tdata,
    // last_of_run
    output logic                     o_m_tuser,
    // last_of_image
    output logic                     o_m_tlast,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state                      r_state;
    t_colour_cfg                 r_cfg;
    logic [PIXEL_COUNT_BITS-1:0] r_image_pixels;
    logic                        r_awaiting;
    logic [RUN_BITS-1:0]         r_run_len;
    logic [RUN_BITS-1:0]         r_remaining;
    logic [PIXEL_COUNT_BITS-1:0] r_pixels_done;
    logic [7:0]                  r_index;
    logic [PIXEL_BITS-1:0]       r_value;
    logic                        r_out_valid;
    logic [PIXEL_BITS-1:0]       r_out_data;
    logic                        r_out_last_run;
    logic                        r_out_last_img;

    t_in_data                    w_in;
    logic                        w_in_fire;
    logic                        w_is_data;
    t_pal_entry                  w_wr_entry;
    t_pal_entry                  w_rd_entry;
    logic [PIXEL_BITS-1:0]       w_pixel;
    logic [PIXEL_COUNT_BITS-1:0] w_target;
    logic [PIXEL_COUNT_BITS:0]   n_pixels_done;
    logic                        w_done;
    logic                        w_last;
    logic                        w_load;

    assign w_in       = t_in_data'(i_s_tdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_is_data  = (t_req'(i_s_tuser) == REQ_DATA);
    assign w_wr_entry = '{red: w_in.pal_red, green: w_in.pal_green, blue: w_in.pal_blue};

    // Writes and reads never meet on one entry in flight: the input is
    // closed while a lookup is under way.
    pcxd_pal_ram u_pal_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_fire && !w_is_data),
        .i_wr_addr (w_in.pal_index),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_in_fire && w_is_data),
        .i_rd_addr (w_in.data_byte),
        .o_rd_data (w_rd_entry)
    );

    pcxd_colour_pack u_colour_pack (
        .i_cfg   (r_cfg),
        .i_index (r_index),
        .i_entry (w_rd_entry),
        .o_pixel (w_pixel)
    );

    // A count of zero behaves as one.
    assign w_target      = (r_image_pixels == '0) ? PIXEL_COUNT_BITS'(1) : r_image_pixels;
    assign n_pixels_done = {1'b0, r_pixels_done} + (PIXEL_COUNT_BITS+1)'(1);
    assign w_done        = (n_pixels_done >= {1'b0, w_target});
    assign w_last        = w_done || (r_remaining == RUN_BITS'(1));
    assign w_load        = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.true_color  <= 1'b1;
            r_cfg.red_width   <= 4'd5;
            r_cfg.green_width <= 4'd6;
            r_cfg.blue_width  <= 4'd5;
            r_cfg.red_shift   <= 5'd11;
            r_cfg.green_shift <= 5'd5;
            r_cfg.blue_shift  <= 5'd0;
            r_image_pixels    <= PIXEL_COUNT_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TRUE_COLOR_MODE: r_cfg.true_color  <= i_cfg_data[0];
                CFG_RED_WIDTH:       r_cfg.red_width   <= i_cfg_data[3:0];
                CFG_GREEN_WIDTH:     r_cfg.green_width <= i_cfg_data[3:0];
                CFG_BLUE_WIDTH:      r_cfg.blue_width  <= i_cfg_data[3:0];
                CFG_RED_SHIFT:       r_cfg.red_shift   <= i_cfg_data[4:0];
                CFG_GREEN_SHIFT:     r_cfg.green_shift <= i_cfg_data[4:0];
                CFG_BLUE_SHIFT:      r_cfg.blue_shift  <= i_cfg_data[4:0];
                CFG_IMAGE_PIXELS:    r_image_pixels    <= i_cfg_data[PIXEL_COUNT_BITS-1:0];
                default:             r_image_pixels    <= r_image_pixels;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_awaiting    <= 1'b0;
            r_run_len     <= '0;
            r_remaining   <= '0;
            r_pixels_done <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire && w_is_data) begin
                        r_index <= w_in.data_byte;
                        priority if (r_awaiting) begin
                            r_awaiting  <= 1'b0;
                            r_run_len   <= '0;
                            r_remaining <= r_run_len;
                            // A zero-length run swallows its value byte.
                            if (r_run_len != '0) begin
                                r_state <= S_LOOK;
                            end
                        end else if (w_in.data_byte < RUN_MARK) begin
                            r_remaining <= RUN_BITS'(1);
                            r_state     <= S_LOOK;
                        end else begin
                            r_awaiting <= 1'b1;
                            r_run_len  <= RUN_BITS'(w_in.data_byte & RUN_MASK);
                        end
                    end
                end
                S_LOOK: begin
                    r_value <= w_pixel;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_valid    <= 1'b1;
                        r_out_data     <= r_value;
                        r_out_last_run <= w_last;
                        r_out_last_img <= w_done;
                        r_remaining    <= r_remaining - RUN_BITS'(1);
                        // Pixels left in a run after the image completes are dropped.
                        r_pixels_done  <= w_done ? '0
                                                 : n_pixels_done[PIXEL_COUNT_BITS-1:0];
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_last_run;
    assign o_m_tlast  = r_out_last_img;

endmodule

[hdl/pcxd_pal_ram.sv]
`timescale 1ns / 1ps
module pcxd_pal_ram
    import pcxd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [PAL_AW-1:0] i_wr_addr,
    input  t_pal_entry        i_wr_data,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_addr,
    output t_pal_entry        o_rd_data
);

    t_pal_entry r_mem [PAL_DEPTH];
    t_pal_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/pcxd_colour_pack.sv]
`timescale 1ns / 1ps
module pcxd_colour_pack
    import pcxd_pkg::*;
(
    input  t_colour_cfg           i_cfg,
    input  logic [7:0]            i_index,
    input  t_pal_entry            i_entry,
    output logic [PIXEL_BITS-1:0] o_pixel
);

    // The channel is scaled to its width, then moved to its field; bits
    // pushed beyond the top of the word are lost, as in the final sum.
    function automatic logic [PIXEL_BITS-1:0] place(input logic [7:0] c,
                                                    input logic [3:0] width,
                                                    input logic [4:0] pos);
        logic [PIXEL_BITS-1:0] scaled;
        scaled = ({{(PIXEL_BITS-8){1'b0}}, c} << width) >> 8;
        return scaled << pos;
    endfunction

    logic [PIXEL_BITS-1:0] w_sum;

    assign w_sum = place(i_entry.red,   i_cfg.red_width,   i_cfg.red_shift)
                 + place(i_entry.green, i_cfg.green_width, i_cfg.green_shift)
                 + place(i_entry.blue,  i_cfg.blue_width,  i_cfg.blue_shift);

    always_comb begin
        priority if (!i_cfg.true_color) begin
            o_pixel = {{(PIXEL_BITS-8){1'b0}}, i_index};
        end else if (i_index == 8'd0) begin
            o_pixel = '0;
        end else begin
            o_pixel = w_sum;
        end
    end

endmodule

[hdl/pcxd_checker.sv]
`timescale 1ns / 1ps
`include "pcx_rle_pixel_decoder_core_assert.svh"
module pcxd_checker
    import pcxd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic                     i_s_tuser,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [PIXEL_BITS-1:0]    o_m_tdata,
    input logic                     o_m_tuser,
    input logic                     o_m_tlast
);

    logic w_pal_xfer;
    logic w_out_stall;

    assign w_pal_xfer  = i_s_tvalid && o_s_tready && !i_s_tuser;
    assign w_out_stall = o_m_tvalid && !i_m_tready;

    // A pending pixel is not withdrawn while the sink stalls.
    `PCXD_ASSERT_NEXT(a_out_valid_held, w_out_stall, o_m_tvalid, "pixel withdrawn under stall")

    // Nor does its content change before the transfer.
    `PCXD_ASSERT_NEXT(a_out_data_held, w_out_stall, $stable({o_m_tdata, o_m_tuser, o_m_tlast}), "pixel changed under stall")

    // The pixel that completes an image always closes its run as well.
    `PCXD_ASSERT_NOW(a_img_end_run, o_m_tvalid && o_m_tlast, o_m_tuser, "run open at image end")

    // A palette write produces no pixels, so the input stays open after it.
    `PCXD_ASSERT_NEXT(a_pal_ready, w_pal_xfer, o_s_tready, "input closed after palette write")

endmodule

bind pcx_rle_pixel_decoder_core pcxd_checker u_pcxd_checker (.*);
